@@ rtl/skm_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyword match package
// Shared constants, keyword table and control types for the shell keyword
// match unit.
// ----------------------------------------------------------------------------
`default_nettype none

package skm_pkg;

    localparam int WINDOW_BYTES = 44;
    localparam int KW_COUNT     = 14;
    localparam int WIN_BITS     = 8 * WINDOW_BYTES;

    typedef logic [WIN_BITS-1:0] kw_vec_t;

    // Controls for the byte window.
    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctrl_t;

    // Byte mask that covers the lowest len bytes of a window word.
    function automatic kw_vec_t len_mask(input int len);
        kw_vec_t m;
        m = '0;
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            if (i < len) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    // A string literal puts its last character in the lowest byte, which is
    // also where the newest window byte sits, so the two line up directly.
    localparam kw_vec_t KW_TEXT [KW_COUNT] = '{
        kw_vec_t'("rm -rf /"),
        kw_vec_t'("rm -rf /system"),
        kw_vec_t'({"enabled_access", "ibility_services"}),
        kw_vec_t'({"ADD_DEVICE", "_ADMIN"}),
        kw_vec_t'("locksettings set-pin"),
        kw_vec_t'("stratum+tcp://"),
        kw_vec_t'("minerd"),
        kw_vec_t'("/dev/block/mmcblk"),
        kw_vec_t'({"am start android.app.action.ADD_DEVICE", "_ADMIN"}),
        kw_vec_t'("settings put secure lock"),
        kw_vec_t'("su persist"),
        kw_vec_t'("install-recovery"),
        kw_vec_t'("adb shell dpm set-device-owner"),
        kw_vec_t'("pm set-install-location")
    };

    localparam kw_vec_t KW_MASK [KW_COUNT] = '{
        len_mask(8),
        len_mask(14),
        len_mask(30),
        len_mask(16),
        len_mask(20),
        len_mask(14),
        len_mask(6),
        len_mask(17),
        len_mask(44),
        len_mask(24),
        len_mask(10),
        len_mask(16),
        len_mask(30),
        len_mask(23)
    };

endpackage

`default_nettype wire

@@ rtl/shell_keyword_match_unit.sv @@
// ----------------------------------------------------------------------------
// Shell keyword match unit
// Scans a byte stream for fixed danger keywords and reports, on the last
// byte of each text, whether any keyword occurred.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, set by the one-byte window shift and the
// parallel keyword comparators between the input and result registers;
// a final byte waits while the result register is still occupied.
// Reset clears the window, the match flag and both valid registers.
`default_nettype none

module shell_keyword_match_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  wire logic       s_axis_tlast,   // end_of_text
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] risk_found, [7:1] zero
);
    import skm_pkg::*;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        seen_reg;
    logic        seen_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        risk_reg;
    logic        risk_next;
    logic        advance;
    logic        any_hit;
    win_ctrl_t   wctrl;
    logic [WIN_BITS-1:0] win_flat;

    // A final byte waits only when the result register is still occupied.
    assign advance = in_valid_reg && (!last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign wctrl.shift = advance;
    assign wctrl.clear = advance && last_reg;

    skm_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (wctrl),
        .new_byte (byte_reg),
        .win_flat (win_flat)
    );

    skm_matcher u_matcher (
        .win_flat (win_flat),
        .any_hit  (any_hit)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;
        risk_next      = risk_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
        if (advance)
        begin
            if (last_reg)
            begin
                out_valid_next = 1'b1;
                risk_next      = seen_reg || any_hit;
                seen_next      = 1'b0;
            end
            else
            begin
                seen_next = seen_reg || any_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            byte_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        risk_reg <= risk_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, risk_reg};

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> out_valid_reg)
        else $error("final byte did not produce a result word");

    a_flag_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> !seen_reg)
        else $error("match flag not cleared after end of text");

    a_hit_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last_reg && any_hit |=> seen_reg)
        else $error("keyword hit not recorded");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && last_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a pending result");

endmodule

`default_nettype wire

@@ rtl/skm_window.sv @@
// ----------------------------------------------------------------------------
// Keyword match byte window
// Shift register of the most recent text bytes; presents the full window
// with the byte now being scanned as its newest entry.
// ----------------------------------------------------------------------------
`default_nettype none

module skm_window (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire skm_pkg::win_ctrl_t ctrl,
    input  wire logic [7:0]         new_byte,
    output logic [skm_pkg::WIN_BITS-1:0] win_flat
);
    import skm_pkg::*;

    localparam int OLD_BITS = 8 * (WINDOW_BYTES - 1);

    // Older bytes, position 1 in the lowest byte.
    logic [OLD_BITS-1:0] win_reg;
    logic [OLD_BITS-1:0] win_next;

    always_comb
    begin
        win_next = win_reg;
        if (ctrl.clear)
        begin
            win_next = '0;
        end
        else if (ctrl.shift)
        begin
            win_next = {win_reg[OLD_BITS-9:0], new_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    assign win_flat = {win_reg, new_byte};

endmodule

`default_nettype wire

@@ rtl/skm_matcher.sv @@
// ----------------------------------------------------------------------------
// Keyword match comparator bank
// Compares every keyword against the newest bytes of the window in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module skm_matcher (
    input  wire logic [skm_pkg::WIN_BITS-1:0] win_flat,
    output logic                              any_hit
);
    import skm_pkg::*;

    logic [KW_COUNT-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            hit[k] = (((win_flat ^ KW_TEXT[k]) & KW_MASK[k]) == '0);
        end
    end

    assign any_hit = |hit;

endmodule

`default_nettype wire

@@ tb/tb_shell_keyword_match_unit.sv @@
// ----------------------------------------------------------------------------
// Shell keyword match unit testbench
// Feeds script texts one byte word at a time and checks the per-text risk
// flag. Traffic starts with a short table of probe texts and their flags.
// Random texts follow, checked against a local scanner with its own byte
// window and keyword list and built from whole, cut and corrupted keywords,
// filler, wild and zero bytes. Both sides idle in random bursts, and the
// receiver holds off for one long stretch while the sender offers words.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_shell_keyword_match_unit;

    localparam int SCAN_DEPTH   = 44;
    localparam int WORD_TOTAL   = 14;
    localparam int RANDOM_BYTES = 1930;
    localparam int MIN_TEXTS    = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        string txt;
        int    zpos;   // position of an inserted zero byte, -1 for none
        bit    risk;
    } probe_row_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    string danger_words [WORD_TOTAL] = '{
        "rm -rf /",
        "rm -rf /system",
        {"enabled_access", "ibility_services"},
        {"ADD_DEVICE", "_ADMIN"},
        "locksettings set-pin",
        "stratum+tcp://",
        "minerd",
        "/dev/block/mmcblk",
        {"am start android.app.action.ADD_DEVICE", "_ADMIN"},
        "settings put secure lock",
        "su persist",
        "install-recovery",
        "adb shell dpm set-device-owner",
        "pm set-install-location"
    };

    // The last two rows split a keyword across two texts, which must not match.
    probe_row_t probe_rows [6] = '{
        '{"",        0, 1'b0},
        '{"\377",   -1, 1'b0},
        '{"minerd", -1, 1'b1},
        '{"minerd",  3, 1'b0},
        '{"rm -r",  -1, 1'b0},
        '{"f /",    -1, 1'b0}
    };

    logic [7:0] tail_bytes [SCAN_DEPTH] = '{default: 8'h00};
    bit         risk_latched = 1'b0;
    bit         pending_risk [$];
    logic [7:0] text_q [$];

    int cycle_count = 0;
    int err_count   = 0;
    int bytes_sent  = 0;
    int texts_done  = 0;
    bit idle_on     = 1'b1;
    bit hold_req    = 1'b0;

    shell_keyword_match_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] text_byte
        .s_axis_tlast  (s_axis_tlast),   // end_of_text
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [0] risk_found, [7:1] zero
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_shell_keyword_match_unit: done, errors");
            $finish;
        end
    end

    // Shift one byte into the local window and return the sticky flag as it
    // stands after this byte. A final byte clears the window and the flag.
    function automatic bit scan_byte(input logic [7:0] b, input logic fin);
        bit hit;
        bit flag_out;
        int n;
        for (int i = SCAN_DEPTH - 1; i > 0; i--)
            tail_bytes[i] = tail_bytes[i-1];
        tail_bytes[0] = b;
        for (int k = 0; k < WORD_TOTAL; k++)
        begin
            n   = danger_words[k].len();
            hit = 1'b1;
            for (int j = 0; j < n; j++)
            begin
                if (tail_bytes[n-1-j] != danger_words[k][j])
                    hit = 1'b0;
            end
            if (hit)
                risk_latched = 1'b1;
        end
        flag_out = risk_latched;
        if (fin)
        begin
            for (int i = 0; i < SCAN_DEPTH; i++)
                tail_bytes[i] = 8'h00;
            risk_latched = 1'b0;
        end
        return flag_out;
    endfunction

    // Most texts are keyword material with random content: whole keywords,
    // cut or corrupted ones, filler, wild bytes and zero bytes. One in ten is
    // pure noise.
    function automatic void compose_text();
        int    target;
        int    pick;
        int    cut;
        int    n;
        bit    tainted;
        bit    noisy;
        string w;
        text_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 5)
            target = 1;
        else if (pick < 15)
            target = $urandom_range(41, 120);
        else
            target = $urandom_range(2, 40);
        tainted = ($urandom_range(0, 2) != 0);
        noisy   = ($urandom_range(0, 9) == 0);
        while (text_q.size() < target)
        begin
            if (noisy)
            begin
                text_q.push_back(8'($urandom_range(0, 255)));
                continue;
            end
            w = danger_words[$urandom_range(0, WORD_TOTAL - 1)];
            n = w.len();
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    if (tainted)
                        for (int j = 0; j < n; j++)
                            text_q.push_back(w[j]);
                end
                2, 3:
                begin
                    cut = $urandom_range(1, n - 1);
                    for (int j = 0; j < cut; j++)
                        text_q.push_back(w[j]);
                end
                4:
                begin
                    cut = $urandom_range(1, n - 1);
                    for (int j = cut; j < n; j++)
                        text_q.push_back(w[j]);
                end
                5:
                begin
                    cut = $urandom_range(0, n - 1);
                    for (int j = 0; j < n; j++)
                        text_q.push_back(j == cut ?
                            w[j] ^ (8'h01 << $urandom_range(0, 7)) : w[j]);
                end
                6, 7:
                begin
                    repeat ($urandom_range(1, 6))
                        text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
                8:
                    text_q.push_back(8'($urandom_range(0, 255)));
                default:
                    text_q.push_back(8'h00);
            endcase
        end
    endfunction

    task automatic note_error(input string what, input int want, input int got);
        err_count++;
        if (err_count <= REPORT_MAX)
            $display("[%0d] %s: expected %0d, got %0d", cycle_count, what, want, got);
    endtask

    // Called at a falling edge; returns at the rising edge that takes the word.
    task automatic offer_byte(input logic [7:0] b, input logic fin);
        if (idle_on && $urandom_range(0, 6) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_text(input bit typed, input bit typed_risk);
        bit r;
        bit fin;
        for (int i = 0; i < text_q.size(); i++)
        begin
            fin = (i == text_q.size() - 1);
            offer_byte(text_q[i], fin);
            r = scan_byte(text_q[i], fin);
            bytes_sent++;
            if (fin)
                pending_risk.push_back(typed ? typed_risk : r);
            @(negedge clk);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_risk.size() == 0)
                note_error("result word with no text pending", -1, m_axis_tdata);
            else
            begin
                if (m_axis_tdata[0] !== pending_risk[0])
                    note_error("risk_found", pending_risk[0], m_axis_tdata[0]);
                if (m_axis_tdata[7:1] !== 7'd0)
                    note_error("tdata pad bits", 0, m_axis_tdata[7:1]);
                void'(pending_risk.pop_front());
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (probe_rows[r])
        begin
            text_q.delete();
            for (int i = 0; i <= probe_rows[r].txt.len(); i++)
            begin
                if (i == probe_rows[r].zpos)
                    text_q.push_back(8'h00);
                if (i < probe_rows[r].txt.len())
                    text_q.push_back(probe_rows[r].txt[i]);
            end
            send_text(1'b1, probe_rows[r].risk);
        end

        // Let the block drain completely before the random traffic.
        s_axis_tvalid <= 1'b0;
        while (pending_risk.size() != 0)
            @(posedge clk);
        @(negedge clk);

        while (bytes_sent < RANDOM_BYTES || texts_done < MIN_TEXTS)
        begin
            if (texts_done == 12)
                hold_req = 1'b1;
            if (bytes_sent > RANDOM_BYTES * 85 / 100)
                idle_on = 1'b0;
            compose_text();
            send_text(1'b0, 1'b0);
            texts_done++;
        end
        s_axis_tvalid <= 1'b0;

        while (pending_risk.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (err_count == 0)
            $display("tb_shell_keyword_match_unit: done, clean");
        else
            $display("tb_shell_keyword_match_unit: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ shell_keyword_match_unit.f @@
rtl/skm_pkg.sv
rtl/skm_window.sv
rtl/skm_matcher.sv
rtl/shell_keyword_match_unit.sv
tb/tb_shell_keyword_match_unit.sv
